// ----- src/set_assoc_lru_cache_model_defines.svh -----
// Assertion macros for the checker file.
`ifndef SET_ASSOC_LRU_CACHE_MODEL_DEFINES_SVH
`define SET_ASSOC_LRU_CACHE_MODEL_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SALC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SALC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/salc_pkg.sv -----
package salc_pkg;

  localparam int MAX_SET_BITS_DEF = 8;
  localparam int MAX_WAYS_DEF     = 8;

  localparam int ADDR_W     = 64;
  localparam int TAG_W      = 63;
  localparam int STAMP_W    = 64;
  localparam int CNT_W      = 32;
  localparam int CMD_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;
  localparam int SET_CFG_W  = 4;
  localparam int OFS_CFG_W  = 6;
  localparam int WAYS_CFG_W = 4;

  localparam logic [CMD_W-1:0] CMD_MODIFY = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SET_BITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_OFS_BITS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WAYS     = 2'd2;

  localparam logic [SET_CFG_W-1:0]  SET_BITS_RST = 4'd1;
  localparam logic [OFS_CFG_W-1:0]  OFS_BITS_RST = 6'd4;
  localparam logic [WAYS_CFG_W-1:0] WAYS_RST     = 4'd1;
  localparam logic [STAMP_W-1:0]    CLOCK_RST    = 64'd1;

  typedef struct packed {
    logic               valid;
    logic [TAG_W-1:0]   tag;
    logic [STAMP_W-1:0] stamp;
  } line_t;

  // add 0..3 to a total, sticking at all ones
  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] cnt,
                                               input logic [1:0] inc);
    logic [CNT_W:0] sum;
    sum = {1'b0, cnt} + (CNT_W + 1)'(inc);
    return sum[CNT_W] ? '1 : sum[CNT_W-1:0];
  endfunction

endpackage

// ----- src/salc_addr_split.sv -----
module salc_addr_split #(
  parameter int SET_W = salc_pkg::MAX_SET_BITS_DEF
) (
  input  logic [salc_pkg::SET_CFG_W-1:0] set_bits,
  input  logic [salc_pkg::OFS_CFG_W-1:0] ofs_bits,
  input  logic [salc_pkg::ADDR_W-1:0]    address,
  output logic [SET_W-1:0]               set_idx,
  output logic [salc_pkg::TAG_W-1:0]     tag
);
  import salc_pkg::*;

  localparam int SHIFT_W = $clog2(2 ** OFS_CFG_W + SET_W);

  logic [OFS_CFG_W-1:0] bb;
  logic [SHIFT_W-1:0]   sb;
  logic [SHIFT_W-1:0]   shift;
  logic [ADDR_W-1:0]    above_ofs;
  logic [ADDR_W-1:0]    set_mask;

  always_comb begin
    bb = (ofs_bits == '0) ? OFS_CFG_W'(1) : ofs_bits;
    if (int'(set_bits) > SET_W) begin
      sb = SHIFT_W'(SET_W);
    end else begin
      sb = SHIFT_W'(set_bits);
    end
    shift     = SHIFT_W'(bb) + sb;
    above_ofs = address >> bb;
    set_mask  = (ADDR_W'(1) << sb) - ADDR_W'(1);
    set_idx   = SET_W'(above_ofs & set_mask);
    // a split that swallows the whole address leaves tag zero
    tag = (int'(shift) >= ADDR_W) ? '0 : TAG_W'(address >> shift);
  end

endmodule

// ----- src/salc_set_mem.sv -----
module salc_set_mem #(
  parameter int SET_W = salc_pkg::MAX_SET_BITS_DEF,
  parameter int WAYS  = salc_pkg::MAX_WAYS_DEF
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [SET_W-1:0]             wr_addr,
  input  salc_pkg::line_t [WAYS-1:0]   wr_row,
  input  logic                         rd_en,
  input  logic [SET_W-1:0]             rd_addr,
  output salc_pkg::line_t [WAYS-1:0]   rd_row
);
  import salc_pkg::*;

  line_t [WAYS-1:0] mem_r [2 ** SET_W];
  line_t [WAYS-1:0] rd_row_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_row;
    end
    if (rd_en) begin
      rd_row_r <= mem_r[rd_addr];
    end
  end

  assign rd_row = rd_row_r;

endmodule

// ----- src/set_assoc_lru_cache_model.sv -----
// A taken request gets a set-memory read, then one way compared per cycle over
// the N ways in use, then its row write, which raises out_valid and waits while
// the output register holds an unaccepted result. A new request is taken only
// after that write, and may be taken while a finished result still waits there.
// Reset (rst_n low, synchronous) starts a clearing pass over all 2**MAX_SET_BITS
// rows of the set memory; in_ready stays low until it ends.
module set_assoc_lru_cache_model #(
  parameter int MAX_SET_BITS = salc_pkg::MAX_SET_BITS_DEF,
  parameter int MAX_WAYS     = salc_pkg::MAX_WAYS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [salc_pkg::CMD_W-1:0]      in_cmd,
  input  logic [salc_pkg::ADDR_W-1:0]     in_address,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_first_hit,
  output logic                            out_first_evicted,
  output logic                            out_second_done,
  output logic [salc_pkg::CNT_W-1:0]      out_hit_total,
  output logic [salc_pkg::CNT_W-1:0]      out_miss_total,
  output logic [salc_pkg::CNT_W-1:0]      out_eviction_total,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [salc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [salc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import salc_pkg::*;

  localparam int SET_W = MAX_SET_BITS;
  localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_SCAN,
    ST_WRITE
  } state_t;

  state_t               state_r, state_nxt;
  logic [SET_W-1:0]     clr_addr_r, clr_addr_nxt;
  logic [SET_CFG_W-1:0] cfg_set_bits_r;
  logic [OFS_CFG_W-1:0] cfg_ofs_bits_r;
  logic [WAYS_CFG_W-1:0] cfg_ways_r;
  logic [SET_W-1:0]     set_r, set_nxt;
  logic [TAG_W-1:0]     tag_r, tag_nxt;
  logic                 modify_r, modify_nxt;
  logic [WAY_W-1:0]     way_r, way_nxt;
  logic                 hit_found_r, hit_found_nxt;
  logic [WAY_W-1:0]     hit_way_r, hit_way_nxt;
  logic [WAY_W-1:0]     victim_r, victim_nxt;
  logic [STAMP_W-1:0]   best_r, best_nxt;
  logic [STAMP_W-1:0]   use_clock_r, use_clock_nxt;
  logic [CNT_W-1:0]     hits_r, hits_nxt;
  logic [CNT_W-1:0]     misses_r, misses_nxt;
  logic [CNT_W-1:0]     evicts_r, evicts_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_hit_r, out_hit_nxt;
  logic                 out_evicted_r, out_evicted_nxt;
  logic                 out_second_r, out_second_nxt;

  logic [SET_W-1:0]        split_set;
  logic [TAG_W-1:0]        split_tag;
  line_t [MAX_WAYS-1:0]    rd_row;
  line_t [MAX_WAYS-1:0]    wr_row;
  line_t [MAX_WAYS-1:0]    new_row;
  line_t                   cur_line;
  line_t                   tgt_line;
  logic [WAY_W-1:0]        tgt_way;
  logic [WAY_W-1:0]        ways_last;
  logic                    tag_match;
  logic                    out_free;
  logic                    evict_now;
  logic                    wr_en;
  logic [SET_W-1:0]        wr_addr;
  logic                    rd_en;

  salc_addr_split #(
    .SET_W (SET_W)
  ) u_split (
    .set_bits (cfg_set_bits_r),
    .ofs_bits (cfg_ofs_bits_r),
    .address  (in_address),
    .set_idx  (split_set),
    .tag      (split_tag)
  );

  salc_set_mem #(
    .SET_W (SET_W),
    .WAYS  (MAX_WAYS)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_row  (wr_row),
    .rd_en   (rd_en),
    .rd_addr (set_r),
    .rd_row  (rd_row)
  );

  always_comb begin
    if (cfg_ways_r == '0) begin
      ways_last = '0;
    end else if (int'(cfg_ways_r) > MAX_WAYS) begin
      ways_last = WAY_W'(MAX_WAYS - 1);
    end else begin
      ways_last = WAY_W'(int'(cfg_ways_r) - 1);
    end
  end

  assign cur_line  = rd_row[way_r];
  assign tag_match = cur_line.valid && (cur_line.tag == tag_r);
  assign tgt_way   = hit_found_r ? hit_way_r : victim_r;
  assign tgt_line  = rd_row[tgt_way];
  assign evict_now = !hit_found_r && tgt_line.valid;
  assign out_free  = !out_valid_r || out_ready;

  // a modify's store hits the same line, so both accesses fold into one write
  always_comb begin
    new_row          = rd_row;
    new_row[tgt_way] = '{valid: 1'b1, tag: tag_r,
                         stamp: modify_r ? use_clock_r + STAMP_W'(1) : use_clock_r};
  end

  assign wr_en   = (state_r == ST_CLEAR) || ((state_r == ST_WRITE) && out_free);
  assign wr_addr = (state_r == ST_CLEAR) ? clr_addr_r : set_r;
  assign wr_row  = (state_r == ST_CLEAR) ? '0 : new_row;
  assign rd_en   = (state_r == ST_READ);

  always_comb begin
    state_nxt       = state_r;
    clr_addr_nxt    = clr_addr_r;
    set_nxt         = set_r;
    tag_nxt         = tag_r;
    modify_nxt      = modify_r;
    way_nxt         = way_r;
    hit_found_nxt   = hit_found_r;
    hit_way_nxt     = hit_way_r;
    victim_nxt      = victim_r;
    best_nxt        = best_r;
    use_clock_nxt   = use_clock_r;
    hits_nxt        = hits_r;
    misses_nxt      = misses_r;
    evicts_nxt      = evicts_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_hit_nxt     = out_hit_r;
    out_evicted_nxt = out_evicted_r;
    out_second_nxt  = out_second_r;

    case (state_r)
      ST_CLEAR: begin
        clr_addr_nxt = clr_addr_r + SET_W'(1);
        if (clr_addr_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          set_nxt    = split_set;
          tag_nxt    = split_tag;
          modify_nxt = (in_cmd == CMD_MODIFY);
          state_nxt  = ST_READ;
        end
      end
      ST_READ: begin
        way_nxt       = '0;
        hit_found_nxt = 1'b0;
        state_nxt     = ST_SCAN;
      end
      ST_SCAN: begin
        // keep the lowest matching way and the lowest way of least stamp
        if (!hit_found_r && tag_match) begin
          hit_found_nxt = 1'b1;
          hit_way_nxt   = way_r;
        end
        if ((way_r == '0) || (cur_line.stamp < best_r)) begin
          best_nxt   = cur_line.stamp;
          victim_nxt = way_r;
        end
        if (way_r == ways_last) begin
          state_nxt = ST_WRITE;
        end else begin
          way_nxt = way_r + WAY_W'(1);
        end
      end
      ST_WRITE: begin
        if (out_free) begin
          use_clock_nxt   = use_clock_r + (modify_r ? STAMP_W'(2) : STAMP_W'(1));
          hits_nxt        = sat_add(hits_r, 2'(hit_found_r) + 2'(modify_r));
          misses_nxt      = sat_add(misses_r, 2'(!hit_found_r));
          evicts_nxt      = sat_add(evicts_r, 2'(evict_now));
          out_valid_nxt   = 1'b1;
          out_hit_nxt     = hit_found_r;
          out_evicted_nxt = evict_now;
          out_second_nxt  = modify_r;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_CLEAR;
      clr_addr_r     <= '0;
      cfg_set_bits_r <= SET_BITS_RST;
      cfg_ofs_bits_r <= OFS_BITS_RST;
      cfg_ways_r     <= WAYS_RST;
      hit_found_r    <= 1'b0;
      use_clock_r    <= CLOCK_RST;
      hits_r         <= '0;
      misses_r       <= '0;
      evicts_r       <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      hit_found_r <= hit_found_nxt;
      use_clock_r <= use_clock_nxt;
      hits_r      <= hits_nxt;
      misses_r    <= misses_nxt;
      evicts_r    <= evicts_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          CFG_IDX_SET_BITS: cfg_set_bits_r <= cfg_data[SET_CFG_W-1:0];
          CFG_IDX_OFS_BITS: cfg_ofs_bits_r <= cfg_data[OFS_CFG_W-1:0];
          CFG_IDX_WAYS:     cfg_ways_r     <= cfg_data[WAYS_CFG_W-1:0];
          default: ;
        endcase
      end
    end
    set_r         <= set_nxt;
    tag_r         <= tag_nxt;
    modify_r      <= modify_nxt;
    way_r         <= way_nxt;
    hit_way_r     <= hit_way_nxt;
    victim_r      <= victim_nxt;
    best_r        <= best_nxt;
    out_hit_r     <= out_hit_nxt;
    out_evicted_r <= out_evicted_nxt;
    out_second_r  <= out_second_nxt;
  end

  assign in_ready           = (state_r == ST_IDLE);
  assign cfg_ready          = 1'b1;
  assign out_valid          = out_valid_r;
  assign out_first_hit      = out_hit_r;
  assign out_first_evicted  = out_evicted_r;
  assign out_second_done    = out_second_r;
  assign out_hit_total      = hits_r;
  assign out_miss_total     = misses_r;
  assign out_eviction_total = evicts_r;

endmodule

// ----- src/salc_checker.sv -----
`include "set_assoc_lru_cache_model_defines.svh"

module salc_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       out_first_hit,
  input logic                       out_first_evicted,
  input logic [salc_pkg::CNT_W-1:0] out_miss_total,
  input logic [salc_pkg::CNT_W-1:0] out_eviction_total
);
  import salc_pkg::*;

  // one request in flight: a taken request drops ready at once
  `SALC_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready, "request taken while busy")

  // a stalled result holds its totals
  `SALC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                    out_valid && $stable(out_miss_total) && $stable(out_eviction_total),
                    "stalled result changed")

  // every eviction comes from a miss
  `SALC_ASSERT_IMP(a_evict_le_miss, out_valid, out_eviction_total <= out_miss_total,
                   "more evictions than misses")

  // a hit never evicts
  `SALC_ASSERT_IMP(a_hit_no_evict, out_valid && out_first_hit, !out_first_evicted,
                   "hit reported an eviction")

endmodule

bind set_assoc_lru_cache_model salc_checker u_salc_checker (.*);

// ----- tb/sv/tb_set_assoc_lru_cache_model.sv -----
module tb_set_assoc_lru_cache_model;
  import salc_pkg::*;

  localparam int LINES      = (1 << MAX_SET_BITS_DEF) * MAX_WAYS_DEF;
  localparam int DRILL_ROWS = 25;
  localparam int PHASES     = 16;
  localparam int PHASE_REQS = 100;
  localparam int LIMIT      = 400000;

  localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_STORE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic             first_hit;
    logic             first_evicted;
    logic             second_done;
    logic [CNT_W-1:0] hits;
    logic [CNT_W-1:0] misses;
    logic [CNT_W-1:0] evictions;
  } cache_result_t;

  typedef enum logic {ROW_REQ, ROW_GEOM} drill_kind_t;

  typedef struct packed {
    drill_kind_t       kind;
    logic [CMD_W-1:0]  cmd;
    logic [ADDR_W-1:0] addr;
    logic [5:0]        set_bits;
    logic [5:0]        ofs_bits;
    logic [5:0]        ways;
    logic              known;
    cache_result_t     want;
  } drill_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [CMD_W-1:0]      in_cmd = CMD_LOAD;
  logic [ADDR_W-1:0]     in_address = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  out_first_hit;
  logic                  out_first_evicted;
  logic                  out_second_done;
  logic [CNT_W-1:0]      out_hit_total;
  logic [CNT_W-1:0]      out_miss_total;
  logic [CNT_W-1:0]      out_eviction_total;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_IDX_SET_BITS;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  set_assoc_lru_cache_model dut (.*);

  // mirror of the cache
  bit                   line_ok   [LINES];
  logic [TAG_W-1:0]     line_tags [LINES];
  logic [STAMP_W-1:0]   line_age  [LINES];
  logic [STAMP_W-1:0]   use_tick;
  logic [CNT_W-1:0]     hits_seen, misses_seen, evict_count;
  logic [SET_CFG_W-1:0]  cur_set_bits;
  logic [OFS_CFG_W-1:0]  cur_ofs_bits;
  logic [WAYS_CFG_W-1:0] cur_ways;

  cache_result_t pending_results [$];
  int unsigned   fail_count = 0;
  int unsigned   cycle_count = 0;
  int unsigned   gap_pct = 24;
  int unsigned   stall_pct = 24;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("[set_assoc_lru_cache_model] ERROR");
      $finish;
    end
  end

  always @(posedge clk) out_ready <= ($urandom_range(99) >= stall_pct);

  function automatic logic [CNT_W-1:0] sat_bump(input logic [CNT_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic void eff_geometry(output int unsigned sb, output int unsigned bb,
                                       output int unsigned ways);
    sb   = (cur_set_bits > MAX_SET_BITS_DEF) ? MAX_SET_BITS_DEF : cur_set_bits;
    bb   = (cur_ofs_bits == 0) ? 1 : cur_ofs_bits;
    ways = (cur_ways == 0) ? 1 : cur_ways;
    if (ways > MAX_WAYS_DEF) ways = MAX_WAYS_DEF;
  endfunction

  function automatic void touch_line(input logic [ADDR_W-1:0] addr, output bit hit,
                                     output bit evicted);
    int unsigned sb, bb, ways, shift, base, victim;
    logic [ADDR_W-1:0]  set_no;
    logic [STAMP_W-1:0] oldest;
    logic [TAG_W-1:0]   tag;
    hit = 1'b0;
    evicted = 1'b0;
    eff_geometry(sb, bb, ways);
    shift  = bb + sb;
    set_no = (addr >> bb) & ((64'd1 << sb) - 64'd1);
    tag    = (shift >= 64) ? '0 : TAG_W'(addr >> shift);
    base   = 32'(set_no) * MAX_WAYS_DEF;
    for (int w = 0; w < ways; w++) begin
      if (line_ok[base+w] && line_tags[base+w] == tag) begin
        line_age[base+w] = use_tick;
        use_tick++;
        hits_seen = sat_bump(hits_seen);
        hit = 1'b1;
        return;
      end
    end
    // lowest-numbered way with the smallest stamp; empty ways sit at zero
    victim = base;
    oldest = line_age[base];
    for (int w = 1; w < ways; w++) begin
      if (line_age[base+w] < oldest) begin
        oldest = line_age[base+w];
        victim = base + w;
      end
    end
    if (line_ok[victim]) begin
      evict_count = sat_bump(evict_count);
      evicted = 1'b1;
    end
    line_ok[victim]   = 1'b1;
    line_tags[victim] = tag;
    line_age[victim]  = use_tick;
    use_tick++;
    misses_seen = sat_bump(misses_seen);
  endfunction

  function automatic cache_result_t predict_request(input logic [CMD_W-1:0] cmd,
                                                    input logic [ADDR_W-1:0] addr);
    cache_result_t r;
    bit h, e, h2, e2;
    touch_line(addr, h, e);
    if (cmd == CMD_MODIFY) touch_line(addr, h2, e2);
    r.first_hit     = h;
    r.first_evicted = e;
    r.second_done   = (cmd == CMD_MODIFY);
    r.hits          = hits_seen;
    r.misses        = misses_seen;
    r.evictions     = evict_count;
    return r;
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_IDX_SET_BITS: cur_set_bits = data[SET_CFG_W-1:0];
      CFG_IDX_OFS_BITS: cur_ofs_bits = data[OFS_CFG_W-1:0];
      CFG_IDX_WAYS:     cur_ways     = data[WAYS_CFG_W-1:0];
      default: ;
    endcase
  endfunction

  task automatic check_field(input string name, input logic [CNT_W-1:0] want,
                             input logic [CNT_W-1:0] got);
    if (want !== got) begin
      $error("%s expected %0d got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    cache_result_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result with no request pending");
        fail_count++;
      end else begin
        exp_r = pending_results.pop_front();
        check_field("first_hit", CNT_W'(exp_r.first_hit), CNT_W'(out_first_hit));
        check_field("first_evicted", CNT_W'(exp_r.first_evicted),
                    CNT_W'(out_first_evicted));
        check_field("second_done", CNT_W'(exp_r.second_done), CNT_W'(out_second_done));
        check_field("hit_total", exp_r.hits, out_hit_total);
        check_field("miss_total", exp_r.misses, out_miss_total);
        check_field("eviction_total", exp_r.evictions, out_eviction_total);
      end
    end
  end

  task automatic pace_sender();
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] addr,
                              input bit known, input cache_result_t want);
    cache_result_t predicted;
    in_valid   <= 1'b1;
    in_cmd     <= cmd;
    in_address <= addr;
    do @(posedge clk); while (!in_ready);
    predicted = predict_request(cmd, addr);
    pending_results.push_back(known ? want : predicted);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // write all three registers back to back once the cache is idle
  task automatic set_geometry(input logic [5:0] sb_data, input logic [5:0] ob_data,
                              input logic [5:0] ways_data);
    logic [CFG_IDX_W-1:0]  idx [3];
    logic [CFG_DATA_W-1:0] val [3];
    idx = '{CFG_IDX_SET_BITS, CFG_IDX_OFS_BITS, CFG_IDX_WAYS};
    val = '{sb_data, ob_data, ways_data};
    drain_results();
    for (int k = 0; k < 3; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= val[k];
      do @(posedge clk); while (!cfg_ready);
      apply_reg(idx[k], val[k]);
    end
    cfg_valid <= 1'b0;
  endtask

  drill_row_t drill_rows [DRILL_ROWS] = '{
    '{kind: ROW_REQ, cmd: CMD_LOAD, addr: 64'h0, known: 1'b1,
      want: '{1'b0, 1'b0, 1'b0, 32'd0, 32'd1, 32'd0}, default: '0},
    '{kind: ROW_REQ, cmd: CMD_LOAD, addr: 64'h8, known: 1'b1,
      want: '{1'b1, 1'b0, 1'b0, 32'd1, 32'd1, 32'd0}, default: '0},
    '{kind: ROW_REQ, cmd: CMD_STORE, addr: 64'h20, known: 1'b1,
      want: '{1'b0, 1'b1, 1'b0, 32'd1, 32'd2, 32'd1}, default: '0},
    '{kind: ROW_REQ, cmd: CMD_MODIFY, addr: 64'h20, known: 1'b1,
      want: '{1'b1, 1'b0, 1'b1, 32'd3, 32'd2, 32'd1}, default: '0},
    '{kind: ROW_REQ, cmd: CMD_UNUSED, addr: 64'hFFFF_FFFF_FFFF_FFFF, known: 1'b1,
      want: '{1'b0, 1'b0, 1'b0, 32'd3, 32'd3, 32'd1}, default: '0},
    '{kind: ROW_REQ, cmd: CMD_MODIFY, addr: 64'h10, known: 1'b1,
      want: '{1'b0, 1'b1, 1'b1, 32'd4, 32'd4, 32'd2}, default: '0},
    // oversized set field, widest offset, oversized ways: tag collapses to zero
    '{kind: ROW_GEOM, set_bits: 6'd15, ofs_bits: 6'd63, ways: 6'd15, default: '0},
    '{kind: ROW_REQ, cmd: CMD_LOAD, addr: 64'h0, default: '0},
    '{kind: ROW_REQ, cmd: CMD_LOAD, addr: 64'h8000_0000_0000_0000, default: '0},
    '{kind: ROW_REQ, cmd: CMD_STORE, addr: 64'hFFFF_FFFF_FFFF_FFFF, default: '0},
    // single set, zero offset acting as one, two ways; old lines stay put
    '{kind: ROW_GEOM, set_bits: 6'd0, ofs_bits: 6'd0, ways: 6'd2, default: '0},
    '{kind: ROW_REQ, cmd: CMD_LOAD, addr: 64'h2, default: '0},
    '{kind: ROW_REQ, cmd: CMD_LOAD, addr: 64'h4, default: '0},
    '{kind: ROW_REQ, cmd: CMD_LOAD, addr: 64'h6, default: '0},
    '{kind: ROW_REQ, cmd: CMD_MODIFY, addr: 64'h4, default: '0},
    '{kind: ROW_REQ, cmd: CMD_LOAD, addr: 64'h7FFF_FFFF_FFFF_FFFE, default: '0},
    // full set field, zero ways acting as one
    '{kind: ROW_GEOM, set_bits: 6'd8, ofs_bits: 6'd32, ways: 6'd0, default: '0},
    '{kind: ROW_REQ, cmd: CMD_STORE, addr: 64'hFFFF_FFFF_0000_0000, default: '0},
    '{kind: ROW_REQ, cmd: CMD_MODIFY, addr: 64'h0000_00FF_0000_0000, default: '0},
    '{kind: ROW_REQ, cmd: CMD_LOAD, addr: 64'h5555_5555_AAAA_AAAA, default: '0},
    '{kind: ROW_GEOM, set_bits: 6'd4, ofs_bits: 6'd1, ways: 6'd8, default: '0},
    '{kind: ROW_REQ, cmd: CMD_LOAD, addr: 64'h2, default: '0},
    '{kind: ROW_REQ, cmd: CMD_STORE, addr: 64'h22, default: '0},
    '{kind: ROW_REQ, cmd: CMD_LOAD, addr: 64'h4002, default: '0},
    '{kind: ROW_REQ, cmd: CMD_MODIFY, addr: 64'h2, default: '0}
  };

  initial begin
    int unsigned      sb, bb, ways, shift, pool_n;
    logic [TAG_W-1:0] tag_pool [10];
    logic [ADDR_W-1:0] set_pool [3];
    logic [ADDR_W-1:0] addr, tag_bits;
    logic [5:0]       sb_data, ob_data, ways_data;
    cache_result_t    none;

    none = '0;
    for (int i = 0; i < LINES; i++) begin
      line_ok[i]  = 1'b0;
      line_age[i] = '0;
    end
    use_tick     = CLOCK_RST;
    hits_seen    = '0;
    misses_seen  = '0;
    evict_count  = '0;
    cur_set_bits = SET_BITS_RST;
    cur_ofs_bits = OFS_BITS_RST;
    cur_ways     = WAYS_RST;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (drill_rows[i]) begin
      if (drill_rows[i].kind == ROW_GEOM) begin
        set_geometry(drill_rows[i].set_bits, drill_rows[i].ofs_bits, drill_rows[i].ways);
      end else begin
        pace_sender();
        send_request(drill_rows[i].cmd, drill_rows[i].addr, drill_rows[i].known,
                     drill_rows[i].want);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      sb_data   = {2'($urandom_range(3)), 4'($urandom_range(15))};
      ways_data = {2'($urandom_range(3)), 4'($urandom_range(15))};
      case ($urandom_range(3))
        0, 1:    ob_data = 6'($urandom_range(1, 12));
        2:       ob_data = 6'($urandom_range(13, 32));
        default: ob_data = 6'($urandom_range(63));
      endcase
      set_geometry(sb_data, ob_data, ways_data);
      // quiet stretch: no gaps on either side
      gap_pct   = (p == 5 || p == 6) ? 0 : 24;
      stall_pct = gap_pct;

      // few sets and a handful of tags per set so lines get reused and evicted
      eff_geometry(sb, bb, ways);
      shift  = sb + bb;
      pool_n = ways + 2;
      for (int k = 0; k < 10; k++)
        tag_pool[k] = (k < 3) ? TAG_W'(k) : TAG_W'({$urandom, $urandom});
      for (int k = 0; k < 3; k++)
        set_pool[k] = 64'($urandom_range((1 << sb) - 1));

      for (int n = 0; n < PHASE_REQS; n++) begin
        if (p == 9 && n == PHASE_REQS / 2) drain_results();
        addr = {$urandom, $urandom};
        if ($urandom_range(9) != 0) begin
          tag_bits = (shift >= 64) ? '0 : 64'(tag_pool[$urandom_range(pool_n - 1)]) << shift;
          addr = (addr & ((64'd1 << bb) - 64'd1)) | (set_pool[$urandom_range(2)] << bb)
                 | tag_bits;
        end
        pace_sender();
        send_request(CMD_W'($urandom_range(3)), addr, 1'b0, none);
      end
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0)
      $display("[set_assoc_lru_cache_model] OK");
    else
      $display("[set_assoc_lru_cache_model] ERROR");
    $finish;
  end

endmodule
